// ===== hdl/cisd_pkg.sv =====
// Shared opcode codes, condition codes, result type and a branch-condition helper for the subopcode decoder.
package cisd_pkg;

    localparam int WordW = 32;
    localparam int OpW   = 5;
    localparam int SubW  = 6;
    localparam int CcW   = 4;

    localparam logic [OpW-1:0] OP_00 = 5'h00;
    localparam logic [OpW-1:0] OP_01 = 5'h01;
    localparam logic [OpW-1:0] OP_04 = 5'h04;
    localparam logic [OpW-1:0] OP_05 = 5'h05;
    localparam logic [OpW-1:0] OP_06 = 5'h06;
    localparam logic [OpW-1:0] OP_07 = 5'h07;
    localparam logic [OpW-1:0] OP_08 = 5'h08;
    localparam logic [OpW-1:0] OP_09 = 5'h09;
    localparam logic [OpW-1:0] OP_0A = 5'h0A;
    localparam logic [OpW-1:0] OP_0B = 5'h0B;
    localparam logic [OpW-1:0] OP_0C = 5'h0C;
    localparam logic [OpW-1:0] OP_0D = 5'h0D;
    localparam logic [OpW-1:0] OP_0E = 5'h0E;
    localparam logic [OpW-1:0] OP_0F = 5'h0F;
    localparam logic [OpW-1:0] OP_17 = 5'h17;
    localparam logic [OpW-1:0] OP_18 = 5'h18;
    localparam logic [OpW-1:0] OP_19 = 5'h19;
    localparam logic [OpW-1:0] OP_1C = 5'h1C;
    localparam logic [OpW-1:0] OP_1D = 5'h1D;
    localparam logic [OpW-1:0] OP_1E = 5'h1E;

    localparam logic [SubW-1:0] SUB_EXT  = 6'h2F;
    localparam logic [SubW-1:0] SUB_ZOP  = 6'h3F;
    localparam logic [2:0]      SUB_CMP  = 3'h7;
    localparam logic [2:0]      SUB_JEQ  = 3'h4;
    localparam logic [2:0]      SUB_JNE  = 3'h5;
    localparam logic [2:0]      SUB_LDB  = 3'h5;
    localparam logic [2:0]      SUB_MVA  = 3'h6;
    localparam logic [2:0]      SUB_MVB  = 3'h7;
    localparam logic [1:0]      BR_EQ    = 2'd1;
    localparam logic [1:0]      BR_NE    = 2'd2;
    localparam logic [1:0]      BR_CC    = 2'd3;

    localparam logic [CcW-1:0] CC_AL = 4'd0;
    localparam logic [CcW-1:0] CC_EQ = 4'd1;
    localparam logic [CcW-1:0] CC_NE = 4'd2;
    localparam logic [CcW-1:0] CC_LO = 4'd5;
    localparam logic [CcW-1:0] CC_HS = 4'd6;
    localparam logic [CcW-1:0] CC_GT = 4'd9;
    localparam logic [CcW-1:0] CC_GE = 4'd10;
    localparam logic [CcW-1:0] CC_LT = 4'd11;
    localparam logic [CcW-1:0] CC_LE = 4'd12;
    localparam logic [CcW-1:0] CC_HI = 4'd13;
    localparam logic [CcW-1:0] CC_LS = 4'd14;

    typedef struct packed {
        logic [OpW-1:0]  major_opcode;
        logic [SubW-1:0] sub_one;
        logic [SubW-1:0] sub_two;
        logic [SubW-1:0] sub_three;
        logic [CcW-1:0]  cond_code;
    } t_dec;

    function automatic logic [CcW-1:0] bcc_map(input logic [2:0] sel);
        logic [CcW-1:0] cc;
        case (sel)
            3'd0:    cc = CC_GT;
            3'd1:    cc = CC_GE;
            3'd2:    cc = CC_LT;
            3'd3:    cc = CC_LE;
            3'd4:    cc = CC_HI;
            3'd5:    cc = CC_HS;
            3'd6:    cc = CC_LO;
            default: cc = CC_LS;
        endcase
        return cc;
    endfunction

endpackage

// ===== hdl/cisd_in_if.sv =====
// Valid/ready channel that carries one instruction word beat.
interface cisd_in_if;
    logic                            valid;
    logic                            ready;
    logic [cisd_pkg::WordW-1:0]      instr_word;
    logic                            is_short;

    modport source (output valid, output instr_word, output is_short, input ready);
    modport sink   (input valid, input instr_word, input is_short, output ready);
endinterface

// ===== hdl/cisd_out_if.sv =====
// Valid/ready channel that carries one decoded result beat.
interface cisd_out_if;
    logic                           valid;
    logic                           ready;
    logic [cisd_pkg::OpW-1:0]       major_opcode;
    logic [cisd_pkg::SubW-1:0]      sub_one;
    logic [cisd_pkg::SubW-1:0]      sub_two;
    logic [cisd_pkg::SubW-1:0]      sub_three;
    logic [cisd_pkg::CcW-1:0]       cond_code;

    modport source (output valid, output major_opcode, output sub_one, output sub_two,
                    output sub_three, output cond_code, input ready);
    modport sink   (input valid, input major_opcode, input sub_one, input sub_two,
                    input sub_three, input cond_code, output ready);
endinterface

// ===== hdl/compact_isa_subopcode_decoder_core.sv =====
// Top level of the instruction subopcode decoder with input and result registers.
//
// Usage: an instruction beat (instr_word, is_short) enters on the i_in channel and one
// decoded beat (major opcode, three subopcode fields, implied condition code) leaves
// on the o_out channel for every beat taken. Both channels move a beat at a rising
// edge where valid and ready are both high.
// An accepted beat is held in the input register, decoded there by shallow logic
// and captured in the result register when that register can advance, from which
// its result is offered. Both registers advance together, so one beat per cycle is
// taken and delivered while the receiver keeps ready high.
// When the receiver stalls, the result register holds its beat and the input register
// fills behind it; i_in.ready drops only when both are full, and rises again in the
// same cycle that the receiver takes the held result.
// A synchronous active-low reset empties both registers; no beats are offered and
// i_in.ready is high in the first cycle after reset.
module compact_isa_subopcode_decoder_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cisd_in_if.sink       i_in,
    cisd_out_if.source    o_out
);

    logic                       r_in_valid;
    logic                       n_in_valid;
    logic [cisd_pkg::WordW-1:0] r_instr_word;
    logic                       r_is_short;
    logic                       r_out_valid;
    logic                       n_out_valid;
    cisd_pkg::t_dec             r_res;
    cisd_pkg::t_dec             dec;
    logic                       adv;
    logic                       take;

    cisd_decode u_decode (
        .i_instr_word (r_instr_word),
        .i_is_short   (r_is_short),
        .o_dec        (dec)
    );

    assign adv        = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || adv;
    assign take       = i_in.valid && i_in.ready;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (adv) begin
            n_out_valid = r_in_valid;
        end
        if (i_in.ready) begin
            n_in_valid = i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_instr_word <= i_in.instr_word;
            r_is_short   <= i_in.is_short;
        end
        if (adv && r_in_valid) begin
            r_res <= dec;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.major_opcode = r_res.major_opcode;
    assign o_out.sub_one      = r_res.sub_one;
    assign o_out.sub_two      = r_res.sub_two;
    assign o_out.sub_three    = r_res.sub_three;
    assign o_out.cond_code    = r_res.cond_code;

endmodule

// ===== hdl/cisd_decode.sv =====
// Combinational opcode and subopcode field decoder.
module cisd_decode (
    input  logic [cisd_pkg::WordW-1:0] i_instr_word,
    input  logic                       i_is_short,
    output cisd_pkg::t_dec             o_dec
);

    logic [cisd_pkg::WordW-1:0] w;
    logic [cisd_pkg::OpW-1:0]   op;
    logic [cisd_pkg::SubW-1:0]  s1;
    logic [cisd_pkg::SubW-1:0]  s2;
    logic [cisd_pkg::SubW-1:0]  s3;
    logic [cisd_pkg::CcW-1:0]   cc;

    assign w  = i_is_short ? {16'h0000, i_instr_word[15:0]} : i_instr_word;
    assign op = i_is_short ? w[15:11] : w[31:27];

    always_comb begin
        s1 = '0;
        s2 = '0;
        s3 = '0;
        cc = cisd_pkg::CC_AL;
        unique case (op) inside
            cisd_pkg::OP_00: begin
                s1 = {5'd0, w[16]};
            end
            cisd_pkg::OP_01: begin
                s1 = {5'd0, w[16]};
                if (w[16]) begin
                    s2 = {5'd0, w[4]};
                    s3 = {2'd0, w[3:0]};
                end else begin
                    s2 = {5'd0, w[17]};
                end
            end
            cisd_pkg::OP_04, cisd_pkg::OP_05, cisd_pkg::OP_06, cisd_pkg::OP_07: begin
                s1 = w[21:16];
                if (w[21:16] == cisd_pkg::SUB_EXT) begin
                    s2 = w[5:0];
                    if (w[5:0] == cisd_pkg::SUB_ZOP) begin
                        s3 = {w[14:12], w[26:24]};
                    end
                end
            end
            cisd_pkg::OP_08: begin
                s1 = {5'd0, w[2]};
            end
            cisd_pkg::OP_09, cisd_pkg::OP_0A: begin
                s1 = w[3] ? 6'd1 : {4'd0, w[4], 1'b0};
            end
            cisd_pkg::OP_0B: begin
                s1 = {5'd0, w[10]};
            end
            cisd_pkg::OP_0C, cisd_pkg::OP_0D: begin
                s1 = {4'd0, w[4:3]};
            end
            cisd_pkg::OP_0E: begin
                s1 = {3'd0, w[4:2]};
            end
            cisd_pkg::OP_0F: begin
                s1 = {1'b0, w[4:0]};
                if (w[4:0] == 5'd0) begin
                    s2 = {3'd0, w[7:5]};
                    if (w[7:5] == cisd_pkg::SUB_CMP) begin
                        s3 = {3'd0, w[10:8]};
                        if (w[10:8] == cisd_pkg::SUB_JEQ) begin
                            cc = cisd_pkg::CC_EQ;
                        end else if (w[10:8] == cisd_pkg::SUB_JNE) begin
                            cc = cisd_pkg::CC_NE;
                        end
                    end
                end
            end
            cisd_pkg::OP_17, cisd_pkg::OP_18: begin
                s1 = {3'd0, w[7:5]};
                if (w[7:5] == cisd_pkg::SUB_LDB) begin
                    s2 = {5'd0, w[8]};
                end else if (w[7:5] == cisd_pkg::SUB_MVA || w[7:5] == cisd_pkg::SUB_MVB) begin
                    s2 = w[0] ? {1'b0, w[4:0]} : 6'd0;
                end
            end
            cisd_pkg::OP_19: begin
                s1 = {4'd0, w[10:9]};
            end
            cisd_pkg::OP_1C: begin
                s1 = {5'd0, w[7]};
            end
            cisd_pkg::OP_1D: begin
                s1 = {5'd0, w[7]};
                cc = w[7] ? cisd_pkg::CC_NE : cisd_pkg::CC_EQ;
            end
            cisd_pkg::OP_1E: begin
                s1 = {4'd0, w[10:9]};
                if (w[10:9] == cisd_pkg::BR_EQ) begin
                    cc = cisd_pkg::CC_EQ;
                end else if (w[10:9] == cisd_pkg::BR_NE) begin
                    cc = cisd_pkg::CC_NE;
                end else if (w[10:9] == cisd_pkg::BR_CC) begin
                    s2 = {3'd0, w[8:6]};
                    cc = cisd_pkg::bcc_map(w[8:6]);
                end
            end
            default: begin
                s1 = '0;
            end
        endcase
    end

    assign o_dec.major_opcode = op;
    assign o_dec.sub_one      = s1;
    assign o_dec.sub_two      = s2;
    assign o_dec.sub_three    = s3;
    assign o_dec.cond_code    = cc;

endmodule

// ===== tb/sv/compact_isa_subopcode_decoder_core_test.sv =====
// Self-checking testbench for the subopcode decoder core with random handshake pacing.
module compact_isa_subopcode_decoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HoldCycles = 50;

    logic           clk;
    logic           rst_n;
    bit             no_idle;
    int             hold_reqs;
    int             errors = 0;
    cisd_pkg::t_dec pending[$];

    cisd_in_if  in_ch();
    cisd_out_if out_ch();

    compact_isa_subopcode_decoder_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [cisd_pkg::CcW-1:0] branch_cond(input logic [2:0] sel);
        logic [cisd_pkg::CcW-1:0] cc;
        case (sel)
            3'd0:    cc = cisd_pkg::CC_GT;
            3'd1:    cc = cisd_pkg::CC_GE;
            3'd2:    cc = cisd_pkg::CC_LT;
            3'd3:    cc = cisd_pkg::CC_LE;
            3'd4:    cc = cisd_pkg::CC_HI;
            3'd5:    cc = cisd_pkg::CC_HS;
            3'd6:    cc = cisd_pkg::CC_LO;
            default: cc = cisd_pkg::CC_LS;
        endcase
        return cc;
    endfunction

    function automatic cisd_pkg::t_dec decode_word(input logic [cisd_pkg::WordW-1:0] word,
                                                   input logic short_form);
        logic [cisd_pkg::WordW-1:0] w;
        cisd_pkg::t_dec d;
        w = short_form ? {16'h0000, word[15:0]} : word;
        d = '0;
        d.major_opcode = short_form ? w[15:11] : w[31:27];
        d.cond_code = cisd_pkg::CC_AL;
        case (d.major_opcode)
            cisd_pkg::OP_00: d.sub_one = {5'd0, w[16]};
            cisd_pkg::OP_01: begin
                d.sub_one = {5'd0, w[16]};
                if (w[16]) begin
                    d.sub_two   = {5'd0, w[4]};
                    d.sub_three = {2'd0, w[3:0]};
                end else begin
                    d.sub_two = {5'd0, w[17]};
                end
            end
            cisd_pkg::OP_04, cisd_pkg::OP_05, cisd_pkg::OP_06, cisd_pkg::OP_07: begin
                d.sub_one = w[21:16];
                if (d.sub_one == cisd_pkg::SUB_EXT) begin
                    d.sub_two = w[5:0];
                    if (d.sub_two == cisd_pkg::SUB_ZOP) begin
                        d.sub_three = {w[14:12], w[26:24]};
                    end
                end
            end
            cisd_pkg::OP_08: d.sub_one = {5'd0, w[2]};
            cisd_pkg::OP_09, cisd_pkg::OP_0A: d.sub_one = w[3] ? 6'd1 : {4'b0000, w[4], 1'b0};
            cisd_pkg::OP_0B: d.sub_one = {5'd0, w[10]};
            cisd_pkg::OP_0C, cisd_pkg::OP_0D: d.sub_one = {4'd0, w[4:3]};
            cisd_pkg::OP_0E: d.sub_one = {3'd0, w[4:2]};
            cisd_pkg::OP_0F: begin
                d.sub_one = {1'b0, w[4:0]};
                if (d.sub_one == 6'd0) begin
                    d.sub_two = {3'd0, w[7:5]};
                    if (w[7:5] == cisd_pkg::SUB_CMP) begin
                        d.sub_three = {3'd0, w[10:8]};
                        if (w[10:8] == cisd_pkg::SUB_JEQ) begin
                            d.cond_code = cisd_pkg::CC_EQ;
                        end else if (w[10:8] == cisd_pkg::SUB_JNE) begin
                            d.cond_code = cisd_pkg::CC_NE;
                        end
                    end
                end
            end
            cisd_pkg::OP_17, cisd_pkg::OP_18: begin
                d.sub_one = {3'd0, w[7:5]};
                if (w[7:5] == cisd_pkg::SUB_LDB) begin
                    d.sub_two = {5'd0, w[8]};
                end else if (w[7:5] == cisd_pkg::SUB_MVA || w[7:5] == cisd_pkg::SUB_MVB) begin
                    d.sub_two = w[0] ? {1'b0, w[4:0]} : 6'd0;
                end
            end
            cisd_pkg::OP_19: d.sub_one = {4'd0, w[10:9]};
            cisd_pkg::OP_1C: d.sub_one = {5'd0, w[7]};
            cisd_pkg::OP_1D: begin
                d.sub_one   = {5'd0, w[7]};
                d.cond_code = w[7] ? cisd_pkg::CC_NE : cisd_pkg::CC_EQ;
            end
            cisd_pkg::OP_1E: begin
                d.sub_one = {4'd0, w[10:9]};
                if (w[10:9] == cisd_pkg::BR_EQ) begin
                    d.cond_code = cisd_pkg::CC_EQ;
                end else if (w[10:9] == cisd_pkg::BR_NE) begin
                    d.cond_code = cisd_pkg::CC_NE;
                end else if (w[10:9] == cisd_pkg::BR_CC) begin
                    d.sub_two   = {3'd0, w[8:6]};
                    d.cond_code = branch_cond(w[8:6]);
                end
            end
            default: ;
        endcase
        return d;
    endfunction

    function automatic logic [cisd_pkg::WordW-1:0] place_op(
        input logic [cisd_pkg::OpW-1:0]   op,
        input logic                       short_form,
        input logic [cisd_pkg::WordW-1:0] body);
        logic [cisd_pkg::WordW-1:0] w;
        w = body;
        if (short_form) begin
            w[15:11] = op;
        end else begin
            w[31:27] = op;
        end
        return w;
    endfunction

    function automatic logic [cisd_pkg::WordW-1:0] make_word(input logic short_form);
        logic [cisd_pkg::WordW-1:0] w;
        logic [cisd_pkg::OpW-1:0]   op;
        w  = $urandom;
        op = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 1) != 0) begin
            case (op)
                cisd_pkg::OP_04, cisd_pkg::OP_05, cisd_pkg::OP_06, cisd_pkg::OP_07: begin
                    w[21:16] = cisd_pkg::SUB_EXT;
                    if ($urandom_range(0, 1) != 0) w[5:0] = cisd_pkg::SUB_ZOP;
                end
                cisd_pkg::OP_0F: begin
                    w[4:0] = 5'd0;
                    if ($urandom_range(0, 3) != 0) w[7:5] = cisd_pkg::SUB_CMP;
                    if ($urandom_range(0, 2) != 0) begin
                        w[10:8] = ($urandom_range(0, 1) != 0) ? cisd_pkg::SUB_JEQ
                                                              : cisd_pkg::SUB_JNE;
                    end
                end
                cisd_pkg::OP_17, cisd_pkg::OP_18: begin
                    case ($urandom_range(0, 2))
                        0:       w[7:5] = cisd_pkg::SUB_LDB;
                        1:       w[7:5] = cisd_pkg::SUB_MVA;
                        default: w[7:5] = cisd_pkg::SUB_MVB;
                    endcase
                end
                default: ;
            endcase
        end
        return place_op(op, short_form, w);
    endfunction

    task automatic send_word(input logic [cisd_pkg::WordW-1:0] word, input logic short_form);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, 8));
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.instr_word = word;
        in_ch.is_short   = short_form;
        do @(posedge clk); while (!in_ch.ready);
        pending.push_back(decode_word(word, short_form));
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        cisd_pkg::t_dec want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending.size() == 0) begin
                $display("%0t ns: unexpected result beat, expected none, actual opcode %0d",
                         $time, out_ch.major_opcode);
                errors++;
            end else begin
                want = pending.pop_front();
                check_field("major_opcode", 32'(want.major_opcode), 32'(out_ch.major_opcode));
                check_field("sub_one", 32'(want.sub_one), 32'(out_ch.sub_one));
                check_field("sub_two", 32'(want.sub_two), 32'(out_ch.sub_two));
                check_field("sub_three", 32'(want.sub_three), 32'(out_ch.sub_three));
                check_field("cond_code", 32'(want.cond_code), 32'(out_ch.cond_code));
            end
        end
    end

    initial begin
        int gap;
        int hold_seen;
        hold_seen    = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_reqs != hold_seen) begin
                hold_seen    = hold_reqs;
                out_ch.ready = 1'b0;
                repeat (HoldCycles) @(negedge clk);
            end
            gap = no_idle ? 0 : int'($urandom_range(0, 8));
            if (gap > 0) begin
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            @(negedge clk);
        end
    end

    task automatic test_directed;
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(place_op(cisd_pkg::OP_04, 1'b1, 32'hFFFF_FFFF), 1'b1);
        send_word(place_op(cisd_pkg::OP_00, 1'b0, 32'h0001_0000), 1'b0);
        send_word(place_op(cisd_pkg::OP_01, 1'b0, 32'h0001_001F), 1'b0);
        send_word(place_op(cisd_pkg::OP_01, 1'b0, 32'h0002_0000), 1'b0);
        send_word(place_op(cisd_pkg::OP_05, 1'b0, 32'h002F_0015), 1'b0);
        send_word(place_op(cisd_pkg::OP_07, 1'b0, 32'h032F_503F), 1'b0);
        send_word(place_op(cisd_pkg::OP_09, 1'b1, 32'h0000_0008), 1'b1);
        send_word(place_op(cisd_pkg::OP_0A, 1'b1, 32'h0000_0010), 1'b1);
        send_word(place_op(cisd_pkg::OP_0F, 1'b1, 32'h0000_04E0), 1'b1);
        send_word(place_op(cisd_pkg::OP_0F, 1'b1, 32'h0000_05E0), 1'b1);
        send_word(place_op(cisd_pkg::OP_0F, 1'b1, 32'h0000_06E0), 1'b1);
        send_word(place_op(cisd_pkg::OP_17, 1'b1, 32'h0000_01A0), 1'b1);
        send_word(place_op(cisd_pkg::OP_18, 1'b1, 32'h0000_00DF), 1'b1);
        send_word(place_op(cisd_pkg::OP_17, 1'b1, 32'h0000_00E0), 1'b1);
        send_word(place_op(cisd_pkg::OP_1D, 1'b1, 32'h0000_0000), 1'b1);
        send_word(place_op(cisd_pkg::OP_1D, 1'b1, 32'h0000_0080), 1'b1);
        send_word(place_op(cisd_pkg::OP_1E, 1'b1, 32'h0000_0200), 1'b1);
        send_word(place_op(cisd_pkg::OP_1E, 1'b1, 32'h0000_0400), 1'b1);
        send_word(place_op(cisd_pkg::OP_1E, 1'b1, 32'h0000_0600), 1'b1);
        send_word(place_op(cisd_pkg::OP_1E, 1'b1, 32'h0000_07C0), 1'b1);
    endtask

    task automatic test_random(input int count, input bit steady);
        logic short_form;
        no_idle = steady;
        repeat (count) begin
            short_form = 1'($urandom_range(0, 1));
            send_word(make_word(short_form), short_form);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure;
        logic short_form;
        no_idle = 1'b1;
        hold_reqs++;
        repeat (30) begin
            short_form = 1'($urandom_range(0, 1));
            send_word(make_word(short_form), short_form);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        rst_n            = 1'b0;
        no_idle          = 1'b0;
        hold_reqs        = 0;
        in_ch.valid      = 1'b0;
        in_ch.instr_word = '0;
        in_ch.is_short   = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(600, 1'b0);
        test_backpressure();
        test_random(300, 1'b1);
        test_random(600, 1'b0);

        in_ch.valid = 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
